@@ hdl/assert_macros.svh @@
// Assertion macros shared by the calendar conversion RTL.
// Depends on nothing; included by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequent holds in the cycle of its antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/esc_pkg.sv @@
// Shared types and constants for the epoch seconds to calendar pipeline.
// No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // seconds / 86400 == (seconds >> 7) * DAY_RECIP >> DAY_SHIFT
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam int unsigned DAY_SHIFT  = 35;
  // x / 1461 == x * CYCLE_RECIP >> 27 for x below 2**16
  localparam logic [16:0] CYCLE_RECIP = 17'd91868;
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
  // x / 3600 == (x >> 4) * HOUR_RECIP >> 21
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  // x / 60 == (x >> 2) * MIN_RECIP >> 14
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  // Days from 1968-01-01 to 1970-01-01, and from 1970-01-01 to 2100-03-01.
  localparam logic [DAYS_W-1:0] EPOCH_OFFSET = 16'd731;
  localparam logic [DAYS_W-1:0] SKIP_2100    = 16'd47541;
  localparam logic [11:0]       BASE_YEAR    = 12'd1968;

  // Day of a four-year cycle on which the second, third and fourth year open.
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic              valid;
    logic [DAYS_W-1:0] days;
    logic [SOD_W-1:0]  sod;
  } esc_split_t;

endpackage

@@ hdl/epoch_seconds_to_calendar.sv @@
// Epoch seconds to UTC calendar date and time: top level of a seven-stage pipeline.
// A request taken at a clock edge passes the day split, then the date and clock
// paths side by side; its result shows on the ports for one cycle, marked by done.
// Throughput: one request per cycle while busy is low; the longest stage is one multiplier.
// Reset (rst, synchronous): clears all valid bits; busy holds high until the first edge after release.
// Depends on esc_pkg, esc_day_split, esc_date, esc_clock, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        epoch_seconds,
  output logic               done,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DAY_W-1:0]   day,
  output logic [HOUR_W-1:0]  hour,
  output logic [MIN_W-1:0]   minute,
  output logic [SEC_W-1:0]   second
);

  esc_split_t split;
  logic       date_valid;
  logic       clock_valid;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start & ~busy;

  esc_day_split u_split (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .epoch_seconds (epoch_seconds),
    .split         (split)
  );

  esc_date u_date (
    .clk   (clk),
    .rst   (rst),
    .split (split),
    .valid (date_valid),
    .year  (year),
    .month (month),
    .day   (day)
  );

  esc_clock u_clock (
    .clk    (clk),
    .rst    (rst),
    .split  (split),
    .valid  (clock_valid),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  assign done = date_valid;

  `ASSERT_ALWAYS(a_paths_aligned, clk, rst, date_valid == clock_valid,
                 "date and time out of step")
  `ASSERT_IMPLY(a_date_range, clk, rst, done,
                (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= 5'd31),
                "date out of range")
  `ASSERT_IMPLY(a_time_range, clk, rst, done,
                (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59),
                "time out of range")

endmodule

@@ hdl/esc_day_split.sv @@
// Splits epoch seconds into whole days and seconds of the day, three stages.
// Depends on esc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esc_day_split
  import esc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [31:0]  epoch_seconds,
  output esc_split_t   split
);

  logic              v1, v2, v3;
  logic [31:0]       secs1, secs2;
  logic [DAYS_W-1:0] days2, days3;
  logic [SOD_W-1:0]  sod3;
  logic [50:0]       day_prod;
  logic [31:0]       day_secs;

  assign day_prod = 51'(secs1[31:7]) * 51'(DAY_RECIP);
  assign day_secs = 32'(days2) * 32'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    secs1 <= epoch_seconds;
    secs2 <= secs1;
    days2 <= day_prod[50:DAY_SHIFT];
    days3 <= days2;
    sod3  <= SOD_W'(secs2 - day_secs);
  end

  assign split.valid = v3;
  assign split.days  = days3;
  assign split.sod   = sod3;

  `ASSERT_IMPLY(a_sod_range, clk, rst, v3, sod3 < SECS_PER_DAY, "seconds of day out of range")
  `ASSERT_IMPLY(a_days_range, clk, rst, v3, days3 <= 16'd49710, "day count out of range")
  `ASSERT_ALWAYS(a_valid_chain, clk, rst, v2 == $past(v1), "valid lost in day split")

endmodule

@@ hdl/esc_date.sv @@
// Turns a day count since 1970-01-01 into year, month and day, four stages.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_date
  import esc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  esc_split_t         split,
  output logic               valid,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DAY_W-1:0]   day
);

  logic              v1, v2, v3;
  logic [DAYS_W-1:0] dprime_next, dprime1, dprime2;
  logic [32:0]       cyc_prod;
  logic [5:0]        cyc2;
  logic [16:0]       cyc_days;
  logic [10:0]       rem;
  logic [1:0]        yic;
  logic [8:0]        doy_next, doy3;
  logic [YEAR_W-1:0] year3;
  logic              leap3;
  logic [3:0]        mon_idx;
  logic [8:0]        mon_base;
  logic [8:0]        start_acc;

  // Count days from 1968-01-01 and insert a phantom 2100-02-29 so that
  // every fourth year is leap across the whole range.
  always_comb begin
    dprime_next = split.days + EPOCH_OFFSET;
    if (split.days >= SKIP_2100) begin
      dprime_next = dprime_next + 16'd1;
    end
  end

  assign cyc_prod = 33'(dprime1) * 33'(CYCLE_RECIP);
  assign cyc_days = 17'(cyc2) * 17'(CYCLE_DAYS);
  assign rem      = 11'(17'(dprime2) - cyc_days);

  always_comb begin
    priority if (rem < YEAR1_START) begin
      yic      = 2'd0;
      doy_next = 9'(rem);
    end else if (rem < YEAR2_START) begin
      yic      = 2'd1;
      doy_next = 9'(rem - YEAR1_START);
    end else if (rem < YEAR3_START) begin
      yic      = 2'd2;
      doy_next = 9'(rem - YEAR2_START);
    end else begin
      yic      = 2'd3;
      doy_next = 9'(rem - YEAR3_START);
    end
  end

  always_comb begin
    mon_idx   = '0;
    mon_base  = '0;
    start_acc = '0;
    for (int i = 1; i < 12; i++) begin
      start_acc = start_acc + 9'(MONTH_LEN[i-1]);
      if (i == 2 && leap3) begin
        start_acc = start_acc + 9'd1;
      end
      if (doy3 >= start_acc) begin
        mon_idx  = 4'(i);
        mon_base = start_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= split.valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
    dprime1 <= dprime_next;
    dprime2 <= dprime1;
    cyc2    <= cyc_prod[32:27];
    year3   <= BASE_YEAR + YEAR_W'({cyc2, yic});
    leap3   <= (yic == 2'd0);
    doy3    <= doy_next;
    year    <= year3;
    month   <= mon_idx + 4'd1;
    day     <= DAY_W'(doy3 - mon_base + 9'd1);
  end

endmodule

@@ hdl/esc_clock.sv @@
// Turns seconds of the day into hour, minute and second, four stages.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_clock
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  esc_split_t        split,
  output logic              valid,
  output logic [HOUR_W-1:0] hour,
  output logic [MIN_W-1:0]  minute,
  output logic [SEC_W-1:0]  second
);

  logic              v1, v2, v3;
  logic [SOD_W-1:0]  sod1;
  logic [26:0]       hour_prod;
  logic [HOUR_W-1:0] hour1, hour2, hour3;
  logic [16:0]       hour_secs;
  logic [11:0]       soh2, soh3;
  logic [20:0]       min_prod;
  logic [MIN_W-1:0]  min3;
  logic [11:0]       min_secs;

  assign hour_prod = 27'(split.sod[16:4]) * 27'(HOUR_RECIP);
  assign hour_secs = 17'(hour1) * 17'(SECS_PER_HOUR);
  assign min_prod  = 21'(soh2[11:2]) * 21'(MIN_RECIP);
  assign min_secs  = 12'(min3) * 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= split.valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
    sod1   <= split.sod;
    hour1  <= hour_prod[25:21];
    hour2  <= hour1;
    soh2   <= 12'(sod1 - hour_secs);
    hour3  <= hour2;
    soh3   <= soh2;
    min3   <= min_prod[19:14];
    hour   <= hour3;
    minute <= min3;
    second <= SEC_W'(soh3 - min_secs);
  end

endmodule
